// ===== design/sorted_insert_priority_queue_unit_defines.svh =====
// ============================================================================
// Assertion macros for the sorted insert priority queue
// Shared helpers for writing clocked assertions with reset gating.
// ============================================================================
`ifndef SORTED_INSERT_PRIORITY_QUEUE_UNIT_DEFINES_SVH
`define SORTED_INSERT_PRIORITY_QUEUE_UNIT_DEFINES_SVH

// Checks a property at every rising clock edge outside of reset.
`define SIPQ_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that a trigger implies a consequence on the next clock edge.
`define SIPQ_ASSERT_NEXT(label, trig, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/sipq_pkg.sv =====
// ============================================================================
// Sorted insert priority queue package
// Sizes, codes and shared types for the queue and its cells.
// ============================================================================
package sipq_pkg;

    localparam int DEPTH = 16;
    localparam int KEY_W = 32;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int OCC_W = 5;
    localparam int STATUS_W = 2;
    localparam int OUT_W = STATUS_W + KEY_W + OCC_W;
    localparam int OUT_DATA_W = ((OUT_W + 7) / 8) * 8;

    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_REMOVE = 1'b1;

    typedef logic signed [KEY_W-1:0] key_t;
    typedef logic [CNT_W-1:0] count_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_UNDERFLOW = 2'd2
    } status_t;

    typedef struct packed {
        logic enable;
        logic remove;
    } cell_ctrl_t;

endpackage

// ===== design/sipq_cell.sv =====
// ============================================================================
// Priority queue cell
// Holds one key, compares it with the incoming key and shifts with neighbors.
// ============================================================================
module sipq_cell (
    input  logic                clk,
    input  sipq_pkg::cell_ctrl_t ctrl,
    input  logic                occupied,
    input  sipq_pkg::key_t      new_key,
    input  sipq_pkg::key_t      left_key,
    input  sipq_pkg::key_t      right_key,
    input  logic                left_stay,
    output sipq_pkg::key_t      key,
    output logic                stay
);

    sipq_pkg::key_t key_reg;
    sipq_pkg::key_t key_next;

    assign stay = occupied && (key_reg < new_key);
    assign key  = key_reg;

    always_comb
    begin
        key_next = key_reg;
        if (ctrl.enable)
        begin
            if (ctrl.remove)
            begin
                key_next = right_key;
            end
            else if (!stay)
            begin
                key_next = left_stay ? new_key : left_key;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

endmodule

// ===== design/sorted_insert_priority_queue_unit.sv =====
// A request's result is registered and appears in the cycle after it is accepted.
// Throughput: one request per cycle while the result side keeps taking results.
// Each accepted request that is not refused updates the whole row of cells in parallel.
// Reset empties the queue; the stored keys themselves are not cleared.
// ============================================================================
// Sorted insert priority queue
// Min-priority queue kept in ascending order in a row of shifting cells.
// ============================================================================
`include "sorted_insert_priority_queue_unit_defines.svh"

module sorted_insert_priority_queue_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,  // key_in
    input  logic        s_tuser,  // mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [sipq_pkg::OUT_DATA_W-1:0] m_tdata  // status, key_out, occupancy
);

    sipq_pkg::count_t     count_reg;
    sipq_pkg::count_t     count_next;
    logic                 m_valid_reg;
    sipq_pkg::status_t    status_reg;
    sipq_pkg::key_t       key_out_reg;
    sipq_pkg::count_t     occ_reg;
    sipq_pkg::status_t    status_next;
    sipq_pkg::key_t       key_out_next;
    sipq_pkg::cell_ctrl_t ctrl;
    sipq_pkg::key_t       new_key;
    sipq_pkg::key_t       cell_key [sipq_pkg::DEPTH];
    logic                 cell_stay [sipq_pkg::DEPTH];
    logic                 fire;
    logic                 is_full;
    logic                 is_empty;

    assign new_key  = sipq_pkg::key_t'(s_tdata);
    assign s_tready = !m_valid_reg || m_tready;
    assign fire     = s_tvalid && s_tready;
    assign is_full  = (count_reg >= sipq_pkg::CNT_W'(sipq_pkg::DEPTH));
    assign is_empty = (count_reg == '0);

    always_comb
    begin
        ctrl.enable  = 1'b0;
        ctrl.remove  = (s_tuser == sipq_pkg::MODE_REMOVE);
        count_next   = count_reg;
        status_next  = sipq_pkg::ST_OK;
        key_out_next = '0;
        if (s_tuser == sipq_pkg::MODE_INSERT)
        begin
            if (is_full)
            begin
                status_next = sipq_pkg::ST_FULL;
            end
            else
            begin
                ctrl.enable = fire;
                count_next  = count_reg + 1'b1;
            end
        end
        else
        begin
            if (is_empty)
            begin
                status_next = sipq_pkg::ST_UNDERFLOW;
            end
            else
            begin
                ctrl.enable  = fire;
                count_next   = count_reg - 1'b1;
                key_out_next = cell_key[0];
            end
        end
    end

    for (genvar i = 0; i < sipq_pkg::DEPTH; i++)
    begin : g_cell
        sipq_pkg::key_t left_key;
        sipq_pkg::key_t right_key;
        logic           left_stay;
        logic           occupied;

        assign occupied = (sipq_pkg::CNT_W'(i) < count_reg);

        if (i == 0)
        begin : g_first
            assign left_key  = new_key;
            assign left_stay = 1'b1;
        end
        else
        begin : g_rest
            assign left_key  = cell_key[i-1];
            assign left_stay = cell_stay[i-1];
        end

        if (i == sipq_pkg::DEPTH - 1)
        begin : g_last
            assign right_key = cell_key[i];
        end
        else
        begin : g_inner
            assign right_key = cell_key[i+1];
        end

        sipq_cell u_cell (
            .clk       (clk),
            .ctrl      (ctrl),
            .occupied  (occupied),
            .new_key   (new_key),
            .left_key  (left_key),
            .right_key (right_key),
            .left_stay (left_stay),
            .key       (cell_key[i]),
            .stay      (cell_stay[i])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            if (fire)
            begin
                count_reg   <= count_next;
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            status_reg  <= status_next;
            key_out_reg <= key_out_next;
            occ_reg     <= count_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = sipq_pkg::OUT_DATA_W'({sipq_pkg::OCC_W'(occ_reg), key_out_reg, status_reg});

    `SIPQ_ASSERT(a_count_bound, count_reg <= sipq_pkg::CNT_W'(sipq_pkg::DEPTH),
        "Queue occupancy exceeds its depth.")
    `SIPQ_ASSERT_NEXT(a_full_refused, fire && s_tuser == sipq_pkg::MODE_INSERT && is_full,
        status_reg == sipq_pkg::ST_FULL && count_reg == $past(count_reg),
        "Insert into a full queue was not refused.")
    `SIPQ_ASSERT_NEXT(a_insert_grows, fire && s_tuser == sipq_pkg::MODE_INSERT && !is_full,
        count_reg == $past(count_reg) + 1'b1,
        "Accepted insert did not raise the occupancy by one.")
    `SIPQ_ASSERT(a_head_sorted, count_reg >= sipq_pkg::CNT_W'(2) |-> cell_key[0] <= cell_key[1],
        "The two smallest keys are out of order.")

endmodule
